>>> rtl/rdt_pkg.sv
package rdt_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CTRL_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PRE_W   = 12;
    localparam int unsigned NUM_SEL = 5;
    localparam int unsigned OUT_W   = 3;

    localparam logic [CTRL_W-1:0] UNF_FLAG   = 16'h0100;
    localparam logic [CTRL_W-1:0] UNF_ENABLE = 16'h0020;
    localparam logic [2:0]        SEL_MASK   = 3'h7;
    localparam logic [DATA_W-1:0] ALL_ONES   = 32'hffff_ffff;

    localparam int unsigned UNF_BIT = 8;
    localparam int unsigned ENA_BIT = 5;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        K_OUTCTL = 3'd0,
        K_START  = 3'd1,
        K_RELOAD = 3'd2,
        K_COUNT  = 3'd3,
        K_CTRL   = 3'd4,
        K_NONE   = 3'd5
    } t_reg_kind;

    typedef struct packed {
        t_reg_kind  kind;
        logic [2:0] chan;
    } t_reg_dec;

    typedef struct packed {
        logic               tick;
        logic [NUM_SEL-1:0] wrap;
        logic               start;
        logic               wr_reload;
        logic               wr_count;
        logic               wr_ctrl;
    } t_chan_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] reload;
        logic [DATA_W-1:0] count;
        logic [CTRL_W-1:0] ctrl;
        logic              pulse;
        logic              irq;
    } t_chan_stat;

    function automatic t_reg_dec rdt_decode(input logic [3:0] idx);
        t_reg_dec d;
        d.chan = 3'd0;
        unique case (idx)
            4'd0:  d.kind = K_OUTCTL;
            4'd1:  d.kind = K_START;
            4'd2:  begin d.kind = K_RELOAD; d.chan = 3'd0; end
            4'd3:  begin d.kind = K_COUNT;  d.chan = 3'd0; end
            4'd4:  begin d.kind = K_CTRL;   d.chan = 3'd0; end
            4'd5:  begin d.kind = K_RELOAD; d.chan = 3'd1; end
            4'd6:  begin d.kind = K_COUNT;  d.chan = 3'd1; end
            4'd7:  begin d.kind = K_CTRL;   d.chan = 3'd1; end
            4'd8:  begin d.kind = K_RELOAD; d.chan = 3'd2; end
            4'd9:  begin d.kind = K_COUNT;  d.chan = 3'd2; end
            4'd10: begin d.kind = K_CTRL;   d.chan = 3'd2; end
            4'd11: begin d.kind = K_RELOAD; d.chan = 3'd3; end
            4'd12: begin d.kind = K_COUNT;  d.chan = 3'd3; end
            4'd13: begin d.kind = K_CTRL;   d.chan = 3'd3; end
            4'd14: begin d.kind = K_RELOAD; d.chan = 3'd4; end
            4'd15: begin d.kind = K_COUNT;  d.chan = 3'd4; end
            default: d.kind = K_NONE;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/rdt_presc.sv
module rdt_presc
    import rdt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    output logic [NUM_SEL-1:0] o_wrap
);

    logic [PRE_W-1:0] r_count;
    logic [PRE_W-1:0] n_count;

    assign n_count = r_count + PRE_W'(1);

    always_comb begin
        for (int s = 0; s < NUM_SEL; s++) begin
            o_wrap[s] = ((n_count & PRE_W'((1 << (4 + 2 * s)) - 1)) == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_tick) begin
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/rdt_chan.sv
module rdt_chan
    import rdt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_chan_cmd         i_cmd,
    input  logic [DATA_W-1:0] i_data,
    output t_chan_stat        o_stat
);

    logic [DATA_W-1:0] r_reload;
    logic [DATA_W-1:0] r_count;
    logic [CTRL_W-1:0] r_ctrl;
    logic [DATA_W-1:0] n_count;
    logic [CTRL_W-1:0] n_ctrl;
    logic              sel_wrap;
    logic              go;
    logic              zero;

    always_comb begin
        unique case (r_ctrl[2:0] & SEL_MASK)
            3'd0:    sel_wrap = i_cmd.wrap[0];
            3'd1:    sel_wrap = i_cmd.wrap[1];
            3'd2:    sel_wrap = i_cmd.wrap[2];
            3'd3:    sel_wrap = i_cmd.wrap[3];
            3'd4:    sel_wrap = i_cmd.wrap[4];
            default: sel_wrap = 1'b0;
        endcase
    end

    assign go   = i_cmd.tick && i_cmd.start && sel_wrap;
    assign zero = (r_count == '0);

    always_comb begin
        n_count = r_count;
        n_ctrl  = r_ctrl;
        if (i_cmd.wr_count) begin
            n_count = i_data;
        end else if (go) begin
            n_count = zero ? r_reload : r_count - DATA_W'(1);
        end
        if (i_cmd.wr_ctrl) begin
            n_ctrl = i_data[CTRL_W-1:0];
        end else if (go && zero) begin
            n_ctrl = r_ctrl | UNF_FLAG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= ALL_ONES;
            r_count  <= ALL_ONES;
            r_ctrl   <= '0;
        end else begin
            if (i_cmd.wr_reload) begin
                r_reload <= i_data;
            end
            r_count <= n_count;
            r_ctrl  <= n_ctrl;
        end
    end

    assign o_stat.reload = r_reload;
    assign o_stat.count  = r_count;
    assign o_stat.ctrl   = r_ctrl;
    assign o_stat.pulse  = go && zero;
    assign o_stat.irq    = n_ctrl[UNF_BIT] && n_ctrl[ENA_BIT];

endmodule

>>> rtl/three_channel_reload_down_timer_top.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_action, i_reg_index, i_write_data
// out       output     o_out_valid / i_out_ready o_read_data, o_interrupt_lines,
//                                                o_underflow_pulses
//
// One item per cycle while results are taken; each item passes through the input
// register, then the result register, with all channel logic in between.
// Reset: counters and reload values all ones, control, start, output control
// and prescaler zero.
// A stalled result holds the input register; in_ready drops only when both are full
// and the result is not taken.
module three_channel_reload_down_timer_top
    import rdt_pkg::*;
#(
    parameter int NUM_CHANNELS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_action,
    input  logic [3:0]        i_reg_index,
    input  logic [DATA_W-1:0] i_write_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_read_data,
    output logic [OUT_W-1:0]  o_interrupt_lines,
    output logic [OUT_W-1:0]  o_underflow_pulses
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int VEC_W  = (NUM_CHANNELS > OUT_W) ? NUM_CHANNELS : OUT_W;
    localparam logic [5:0] REG_END = 6'(2 + 3 * NUM_CHANNELS);

    logic              r_in_valid;
    t_action           r_action;
    logic [3:0]        r_idx;
    logic [DATA_W-1:0] r_data;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data;
    logic [OUT_W-1:0]  r_irq;
    logic [OUT_W-1:0]  r_pulse;

    logic [BYTE_W-1:0] r_outctl;
    logic [BYTE_W-1:0] r_start;

    logic               advance;
    logic               fire;
    logic               do_tick;
    logic               do_read;
    logic               do_write;
    t_reg_dec           dec;
    t_reg_kind          kind;
    logic [CH_W-1:0]    ch;
    logic [NUM_SEL-1:0] wrap;
    logic [DATA_W-1:0]  n_read_data;

    logic [NUM_CHANNELS-1:0] irq_vec;
    logic [NUM_CHANNELS-1:0] pulse_vec;
    logic [VEC_W-1:0]        irq_wide;
    logic [VEC_W-1:0]        pulse_wide;

    t_chan_cmd  cmd  [NUM_CHANNELS];
    t_chan_stat stat [NUM_CHANNELS];

    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_action <= t_action'(i_action);
            r_idx    <= i_reg_index;
            r_data   <= i_write_data;
        end
    end

    always_comb begin
        do_tick  = 1'b0;
        do_read  = 1'b0;
        do_write = 1'b0;
        unique case (r_action)
            ACT_TICK:  do_tick  = fire;
            ACT_READ:  do_read  = fire;
            ACT_WRITE: do_write = fire;
            ACT_NOP:   ;
            default:   ;
        endcase
    end

    always_comb begin
        dec  = rdt_decode(r_idx);
        kind = ({2'b00, r_idx} >= REG_END) ? K_NONE : dec.kind;
        ch   = CH_W'(dec.chan);
    end

    rdt_presc u_presc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (do_tick),
        .o_wrap  (wrap)
    );

    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
        always_comb begin
            cmd[c].tick      = do_tick;
            cmd[c].wrap      = wrap;
            cmd[c].start     = r_start[c];
            cmd[c].wr_reload = do_write && (kind == K_RELOAD) && (ch == CH_W'(c));
            cmd[c].wr_count  = do_write && (kind == K_COUNT) && (ch == CH_W'(c));
            cmd[c].wr_ctrl   = do_write && (kind == K_CTRL) && (ch == CH_W'(c));
        end

        rdt_chan u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd[c]),
            .i_data  (r_data),
            .o_stat  (stat[c])
        );

        assign irq_vec[c]   = stat[c].irq;
        assign pulse_vec[c] = stat[c].pulse;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outctl <= '0;
            r_start  <= '0;
        end else if (do_write) begin
            if (kind == K_OUTCTL) begin
                r_outctl <= r_data[BYTE_W-1:0];
            end
            if (kind == K_START) begin
                r_start <= r_data[BYTE_W-1:0];
            end
        end
    end

    always_comb begin
        n_read_data = '0;
        if (do_read) begin
            unique case (kind)
                K_OUTCTL: n_read_data = DATA_W'(r_outctl);
                K_START:  n_read_data = DATA_W'(r_start);
                K_RELOAD: n_read_data = stat[ch].reload;
                K_COUNT:  n_read_data = stat[ch].count;
                K_CTRL:   n_read_data = DATA_W'(stat[ch].ctrl);
                K_NONE:   n_read_data = '0;
                default:  n_read_data = '0;
            endcase
        end
    end

    assign irq_wide   = VEC_W'(irq_vec);
    assign pulse_wide = VEC_W'(pulse_vec);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_read_data <= n_read_data;
            r_irq       <= irq_wide[OUT_W-1:0];
            r_pulse     <= pulse_wide[OUT_W-1:0];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_read_data        = r_read_data;
    assign o_interrupt_lines  = r_irq;
    assign o_underflow_pulses = r_pulse;

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import rdt_pkg::*;

    localparam int NCH         = 3;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 8;

    localparam logic [3:0] REG_OUTCTL  = 4'd0;
    localparam logic [3:0] REG_START   = 4'd1;
    localparam int unsigned REG_CHAN_BASE = 2;
    localparam int unsigned REG_STRIDE    = 3;
    localparam int unsigned OFS_RELOAD    = 0;
    localparam int unsigned OFS_COUNT     = 1;
    localparam int unsigned OFS_CTRL      = 2;
    localparam logic [3:0] REG_CAPTURE = 4'(REG_CHAN_BASE + REG_STRIDE * NCH);
    localparam logic [3:0] REG_TOP     = 4'd15;

    localparam logic [2:0] SEL_DIV16   = 3'd0;
    localparam logic [2:0] SEL_DIV64   = 3'd1;
    localparam logic [2:0] SEL_DIV256  = 3'd2;
    localparam logic [2:0] SEL_DIV1024 = 3'd3;
    localparam logic [2:0] SEL_DIV4096 = 3'd4;
    localparam logic [2:0] SEL_STOP_LO = 3'd5;
    localparam logic [2:0] SEL_STOP_HI = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic [OUT_W-1:0]  irq;
        logic [OUT_W-1:0]  unf;
    } t_timer_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_action;
    logic [3:0]        i_reg_index;
    logic [DATA_W-1:0] i_write_data;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [DATA_W-1:0] o_read_data;
    logic [OUT_W-1:0]  o_interrupt_lines;
    logic [OUT_W-1:0]  o_underflow_pulses;

    logic [DATA_W-1:0] tmr_count   [NCH];
    logic [DATA_W-1:0] tmr_reload  [NCH];
    logic [CTRL_W-1:0] tmr_ctrl    [NCH];
    logic [BYTE_W-1:0] tmr_start;
    logic [BYTE_W-1:0] tmr_outctl;
    logic [PRE_W-1:0]  tmr_prescale;

    t_timer_result pending_timer_results[$];
    t_timer_result oldest_expected;

    int fail_count       = 0;
    int items_sent       = 0;
    int quiet_cycles     = 0;
    int sink_hold_cycles = 0;
    bit sink_steady      = 1'b0;
    bit src_steady       = 1'b0;

    three_channel_reload_down_timer_top #(
        .NUM_CHANNELS(NCH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_reg_index        (i_reg_index),
        .i_write_data       (i_write_data),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_read_data        (o_read_data),
        .o_interrupt_lines  (o_interrupt_lines),
        .o_underflow_pulses (o_underflow_pulses)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void timer_clear();
        for (int c = 0; c < NCH; c++) begin
            tmr_count[c]  = ALL_ONES;
            tmr_reload[c] = ALL_ONES;
            tmr_ctrl[c]   = '0;
        end
        tmr_start    = '0;
        tmr_outctl   = '0;
        tmr_prescale = '0;
    endfunction

    function automatic logic [OUT_W-1:0] timer_irq();
        logic [OUT_W-1:0] lines;
        lines = '0;
        for (int c = 0; c < NCH && c < OUT_W; c++) begin
            lines[c] = tmr_ctrl[c][UNF_BIT] && tmr_ctrl[c][ENA_BIT];
        end
        return lines;
    endfunction

    function automatic logic [OUT_W-1:0] timer_tick();
        logic [OUT_W-1:0] unf;
        int unsigned      span;
        unf = '0;
        tmr_prescale = tmr_prescale + 1'b1;
        for (int c = 0; c < NCH; c++) begin
            if (tmr_start[c] && tmr_ctrl[c][2:0] < NUM_SEL) begin
                span = (1 << (4 + 2 * tmr_ctrl[c][2:0])) - 1;
                if ((tmr_prescale & span) == 0) begin
                    if (tmr_count[c] == '0) begin
                        tmr_count[c] = tmr_reload[c];
                        tmr_ctrl[c]  = tmr_ctrl[c] | UNF_FLAG;
                        if (c < OUT_W) unf[c] = 1'b1;
                    end else begin
                        tmr_count[c] = tmr_count[c] - 1'b1;
                    end
                end
            end
        end
        return unf;
    endfunction

    function automatic logic [DATA_W-1:0] timer_reg_read(logic [3:0] idx);
        int unsigned ch;
        int unsigned ofs;
        if (idx == REG_OUTCTL) return DATA_W'(tmr_outctl);
        if (idx == REG_START) return DATA_W'(tmr_start);
        if (idx >= REG_CAPTURE) return '0;
        ch  = (idx - REG_CHAN_BASE) / REG_STRIDE;
        ofs = (idx - REG_CHAN_BASE) % REG_STRIDE;
        if (ofs == OFS_RELOAD) return tmr_reload[ch];
        if (ofs == OFS_COUNT) return tmr_count[ch];
        return DATA_W'(tmr_ctrl[ch]);
    endfunction

    function automatic void timer_reg_write(logic [3:0] idx, logic [DATA_W-1:0] wdata);
        int unsigned ch;
        int unsigned ofs;
        if (idx == REG_OUTCTL) begin
            tmr_outctl = wdata[BYTE_W-1:0];
        end else if (idx == REG_START) begin
            tmr_start = wdata[BYTE_W-1:0];
        end else if (idx < REG_CAPTURE) begin
            ch  = (idx - REG_CHAN_BASE) / REG_STRIDE;
            ofs = (idx - REG_CHAN_BASE) % REG_STRIDE;
            if (ofs == OFS_RELOAD) tmr_reload[ch] = wdata;
            else if (ofs == OFS_COUNT) tmr_count[ch] = wdata;
            else tmr_ctrl[ch] = wdata[CTRL_W-1:0];
        end
    endfunction

    function automatic t_timer_result timer_step(t_action act, logic [3:0] idx,
                                                 logic [DATA_W-1:0] wdata);
        t_timer_result r;
        r = '0;
        case (act)
            ACT_TICK:  r.unf = timer_tick();
            ACT_READ:  r.rdata = timer_reg_read(idx);
            ACT_WRITE: timer_reg_write(idx, wdata);
            default: ;
        endcase
        r.irq = timer_irq();
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pending_timer_results.push_back(
                timer_step(t_action'(i_action), i_reg_index, i_write_data));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_timer_results.size() == 0) begin
                $error("result transfer with no result expected");
                fail_count++;
            end else begin
                oldest_expected = pending_timer_results.pop_front();
                if (o_read_data !== oldest_expected.rdata) begin
                    $error("read_data: expected %h, got %h",
                           oldest_expected.rdata, o_read_data);
                    fail_count++;
                end
                if (o_interrupt_lines !== oldest_expected.irq) begin
                    $error("interrupt_lines: expected %h, got %h",
                           oldest_expected.irq, o_interrupt_lines);
                    fail_count++;
                end
                if (o_underflow_pulses !== oldest_expected.unf) begin
                    $error("underflow_pulses: expected %h, got %h",
                           oldest_expected.unf, o_underflow_pulses);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("three_channel_reload_down_timer_top regression: fail");
        $finish;
    end

    function automatic int short_or_long(int unsigned pct_none);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < pct_none) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        int hold;
        forever begin
            if ($urandom_range(0, 99) == 0) sink_steady = !sink_steady;
            if (sink_hold_cycles != 0) begin
                hold = sink_hold_cycles;
                sink_hold_cycles = 0;
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else if (sink_steady || $urandom_range(0, 3) != 0) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat (short_or_long(0)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input t_action act, input logic [3:0] idx,
                             input logic [DATA_W-1:0] data);
        int gap;
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_reg_index  <= idx;
        i_write_data <= data;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if ($urandom_range(0, 63) == 0) src_steady = !src_steady;
        gap = src_steady ? 0 : short_or_long(60);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_timer_results.size() != 0);
    endtask

    function automatic logic [3:0] chan_reg(int c, int unsigned ofs);
        return 4'(REG_CHAN_BASE + REG_STRIDE * c + ofs);
    endfunction

    function automatic logic [2:0] pick_selector();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return SEL_DIV16;
        if (r < 8) return SEL_DIV64;
        if (r < 9) return SEL_DIV256;
        return 3'($urandom_range(SEL_STOP_LO, SEL_STOP_HI));
    endfunction

    function automatic logic [DATA_W-1:0] small_or_wide();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, 3);
    endfunction

    task automatic test_reset_values();
        for (int i = 0; i <= REG_TOP; i++) begin
            send_item(ACT_READ, 4'(i), $urandom);
        end
    endtask

    task automatic test_register_extremes();
        send_item(ACT_WRITE, REG_OUTCTL, ALL_ONES);
        send_item(ACT_READ, REG_OUTCTL, '0);
        send_item(ACT_WRITE, REG_OUTCTL, '0);
        send_item(ACT_WRITE, chan_reg(0, OFS_RELOAD), '0);
        send_item(ACT_READ, chan_reg(0, OFS_RELOAD), '0);
        send_item(ACT_WRITE, chan_reg(2, OFS_CTRL), ALL_ONES);
        send_item(ACT_READ, chan_reg(2, OFS_CTRL), '0);
        send_item(ACT_WRITE, REG_CAPTURE, ALL_ONES);
        send_item(ACT_READ, REG_CAPTURE, '0);
        send_item(ACT_WRITE, REG_TOP, ALL_ONES);
        send_item(ACT_NOP, REG_OUTCTL, ALL_ONES);
        send_item(ACT_READ, REG_OUTCTL, '0);
        send_item(ACT_WRITE, chan_reg(2, OFS_CTRL), '0);
    endtask

    task automatic test_backpressure();
        sink_hold_cycles = 200;
        for (int i = 0; i < 40; i++) begin
            if ($urandom_range(0, 3) == 0) send_item(ACT_READ, 4'($urandom), $urandom);
            else send_item(ACT_TICK, 4'($urandom), $urandom);
        end
    endtask

    task automatic program_channel(int c);
        logic [CTRL_W-1:0] ctrl;
        logic [DATA_W-1:0] start;
        ctrl = CTRL_W'($urandom);
        ctrl[2:0] = pick_selector();
        ctrl[UNF_BIT] = ($urandom_range(0, 7) == 0);
        start = $urandom;
        start[c] = ($urandom_range(0, 9) != 0);
        send_item(ACT_WRITE, chan_reg(c, OFS_RELOAD), small_or_wide());
        send_item(ACT_WRITE, chan_reg(c, OFS_COUNT), small_or_wide());
        send_item(ACT_WRITE, chan_reg(c, OFS_CTRL), DATA_W'(ctrl) | ($urandom & ~32'hffff));
        send_item(ACT_WRITE, REG_START, start);
    endtask

    task automatic tick_burst(int len);
        int c;
        for (int i = 0; i < len; i++) begin
            c = $urandom_range(0, NCH - 1);
            case ($urandom_range(0, 39))
                0, 1, 2, 3: send_item(ACT_READ, 4'($urandom), $urandom);
                4:          send_item(ACT_WRITE, chan_reg(c, OFS_COUNT), small_or_wide());
                5:          send_item(ACT_WRITE, chan_reg(c, OFS_CTRL),
                                      DATA_W'(tmr_ctrl[c] & ~UNF_FLAG));
                default:    send_item(ACT_TICK, 4'($urandom), $urandom);
            endcase
        end
    endtask

    task automatic test_timer_sequences(int target);
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    program_channel($urandom_range(0, NCH - 1));
                    tick_burst($urandom_range(16, 200));
                end
                6, 7: begin
                    repeat ($urandom_range(1, 8)) begin
                        send_item(t_action'($urandom_range(0, 3)), 4'($urandom), $urandom);
                    end
                end
                default: begin
                    repeat ($urandom_range(3, 6)) send_item(ACT_READ, 4'($urandom), $urandom);
                end
            endcase
        end
    endtask

    task automatic test_slow_dividers();
        logic [2:0] sel [NCH];
        sel[0] = SEL_DIV256;
        sel[1] = SEL_DIV1024;
        sel[2] = SEL_DIV4096;
        for (int c = 0; c < NCH; c++) begin
            send_item(ACT_WRITE, chan_reg(c, OFS_RELOAD), $urandom_range(0, 2));
            send_item(ACT_WRITE, chan_reg(c, OFS_COUNT), '0);
            send_item(ACT_WRITE, chan_reg(c, OFS_CTRL), DATA_W'(UNF_ENABLE) | sel[c]);
        end
        send_item(ACT_WRITE, REG_START, DATA_W'((1 << NCH) - 1));
        repeat (1100) send_item(ACT_TICK, 4'($urandom), $urandom);
        for (int c = 0; c < NCH; c++) begin
            send_item(ACT_READ, chan_reg(c, OFS_COUNT), '0);
            send_item(ACT_READ, chan_reg(c, OFS_CTRL), '0);
            send_item(ACT_WRITE, chan_reg(c, OFS_CTRL), DATA_W'(SEL_DIV1024));
        end
        send_item(ACT_WRITE, REG_START, '0);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_action     <= ACT_TICK;
        i_reg_index  <= '0;
        i_write_data <= '0;
        timer_clear();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_register_extremes();
        drain_results();
        test_backpressure();
        drain_results();
        test_timer_sequences(500);
        drain_results();
        test_slow_dividers();
        drain_results();

        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending_timer_results.size() == 0) begin
            $display("three_channel_reload_down_timer_top regression: pass");
        end else begin
            $display("three_channel_reload_down_timer_top regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rdt_pkg.sv
rtl/rdt_presc.sv
rtl/rdt_chan.sv
rtl/three_channel_reload_down_timer_top.sv
dv/tb.sv
